### sv/rotenc_pkg.sv
`timescale 1ns / 1ps

package rotenc_pkg;

    localparam int TICK_WIDTH = 32;
    localparam int NOW_W      = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int POS_W      = 32;

    localparam logic [CFG_W-1:0] LOCKOUT_RESET = 16'd10;
    localparam logic [CFG_W-1:0] HOLDOFF_RESET = 16'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 1'b1;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_SW  = 1'b1;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } step_t;

    typedef logic [2:0] dec_state_t;

    localparam dec_state_t DEC_START = 3'd0;
    localparam dec_state_t DEC_LAST  = 3'd6;

    // Table entry: direction flags in bits 5:4, next decoder state in bits 2:0.
    localparam logic [5:0] DIR_CW_FLAG  = 6'h10;
    localparam logic [5:0] DIR_CCW_FLAG = 6'h20;
    localparam logic [5:0] DIR_MASK     = 6'h30;

    localparam logic [5:0] STEP_TABLE [0:6][0:3] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h10},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h20},
        '{6'h06, 6'h05, 6'h04, 6'h00}
    };

    typedef struct packed {
        logic             op;
        logic             pin_a;
        logic             pin_b;
        logic             pin_sw;
        logic [NOW_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] lockout;
        logic [CFG_W-1:0] holdoff;
    } cfg_t;

endpackage

### sv/rotenc_cfg.sv
`timescale 1ns / 1ps

module rotenc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotenc_pkg::CFG_W-1:0]         cfg_wdata,
    output rotenc_pkg::cfg_t                     cfg
);

    logic [rotenc_pkg::CFG_W-1:0] lockout_reg;
    logic [rotenc_pkg::CFG_W-1:0] holdoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= rotenc_pkg::LOCKOUT_RESET;
            holdoff_reg <= rotenc_pkg::HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rotenc_pkg::CFG_LOCKOUT: lockout_reg <= cfg_wdata;
                rotenc_pkg::CFG_HOLDOFF: holdoff_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.lockout = lockout_reg;
    assign cfg.holdoff = holdoff_reg;

endmodule

### sv/rotenc_in_reg.sv
`timescale 1ns / 1ps

module rotenc_in_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic                           pin_a,
    input  logic                           pin_b,
    input  logic                           pin_sw,
    input  logic [rotenc_pkg::NOW_W-1:0]   now_ms,
    output logic                           item_valid,
    output rotenc_pkg::item_t              item,
    input  logic                           item_take
);

    logic              valid_reg;
    rotenc_pkg::item_t item_reg;

    assign in_ready = !valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.op     <= op;
            item_reg.pin_a  <= pin_a;
            item_reg.pin_b  <= pin_b;
            item_reg.pin_sw <= pin_sw;
            item_reg.now_ms <= now_ms;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/rotenc_core.sv
`timescale 1ns / 1ps

module rotenc_core #(
    parameter int TICK_WIDTH = rotenc_pkg::TICK_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rotenc_pkg::cfg_t               cfg,
    input  logic                           item_valid,
    input  rotenc_pkg::item_t              item,
    output logic                           item_take,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [rotenc_pkg::POS_W-1:0] position,
    output logic [1:0]                     step,
    output logic                           tap
);

    rotenc_pkg::dec_state_t          dec_state_reg, dec_state_next;
    logic [1:0]                      last_lines_reg, last_lines_next;
    logic                            lines_valid_reg, lines_valid_next;
    logic [rotenc_pkg::POS_W-1:0]    count_reg, count_next;
    logic [TICK_WIDTH-1:0]           rot_time_reg, rot_time_next;
    logic                            held_reg, held_next;
    logic [TICK_WIDTH-1:0]           tap_time_reg, tap_time_next;

    logic                            out_valid_reg;
    logic [rotenc_pkg::POS_W-1:0]    position_reg;
    rotenc_pkg::step_t               step_reg, step_next;
    logic                            tap_reg, tap_next;

    logic [1:0]                      ab;
    logic [TICK_WIDTH-1:0]           now;
    logic [TICK_WIDTH-1:0]           since_rot;
    logic [TICK_WIDTH-1:0]           since_tap;
    rotenc_pkg::dec_state_t          cur;
    logic [5:0]                      entry;

    assign item_take = item_valid && (!out_valid_reg || out_ready);

    assign ab        = {item.pin_a, item.pin_b};
    assign now       = item.now_ms[TICK_WIDTH-1:0];
    assign since_rot = now - rot_time_reg;
    assign since_tap = now - tap_time_reg;
    assign cur       = (dec_state_reg > rotenc_pkg::DEC_LAST) ? rotenc_pkg::DEC_START
                                                              : dec_state_reg;
    assign entry     = rotenc_pkg::STEP_TABLE[cur][ab];

    always_comb
    begin
        dec_state_next   = dec_state_reg;
        last_lines_next  = last_lines_reg;
        lines_valid_next = lines_valid_reg;
        count_next       = count_reg;
        rot_time_next    = rot_time_reg;
        held_next        = held_reg;
        tap_time_next    = tap_time_reg;
        step_next        = rotenc_pkg::STEP_NONE;
        tap_next         = 1'b0;

        if (item.op == rotenc_pkg::OP_ENC)
        begin
            if (item.pin_sw && !(lines_valid_reg && ab == last_lines_reg))
            begin
                last_lines_next  = ab;
                lines_valid_next = 1'b1;
                rot_time_next    = now;
                dec_state_next   = entry[2:0];
                if ((entry & rotenc_pkg::DIR_MASK) == rotenc_pkg::DIR_CW_FLAG)
                begin
                    count_next = count_reg + 1'b1;
                    step_next  = rotenc_pkg::STEP_CW;
                end
                else if ((entry & rotenc_pkg::DIR_MASK) == rotenc_pkg::DIR_CCW_FLAG)
                begin
                    count_next = count_reg - 1'b1;
                    step_next  = rotenc_pkg::STEP_CCW;
                end
            end
        end
        else
        begin
            if (!item.pin_sw)
            begin
                if (since_rot >= TICK_WIDTH'(cfg.lockout) && !held_reg &&
                    since_tap >= TICK_WIDTH'(cfg.holdoff))
                begin
                    held_next     = 1'b1;
                    tap_time_next = now;
                    tap_next      = 1'b1;
                end
            end
            else
            begin
                held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_state_reg   <= rotenc_pkg::DEC_START;
            last_lines_reg  <= 2'b00;
            lines_valid_reg <= 1'b0;
            count_reg       <= '0;
            rot_time_reg    <= '0;
            held_reg        <= 1'b0;
            tap_time_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                dec_state_reg   <= dec_state_next;
                last_lines_reg  <= last_lines_next;
                lines_valid_reg <= lines_valid_next;
                count_reg       <= count_next;
                rot_time_reg    <= rot_time_next;
                held_reg        <= held_next;
                tap_time_reg    <= tap_time_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            position_reg <= count_next;
            step_reg     <= step_next;
            tap_reg      <= tap_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign step      = step_reg;
    assign tap       = tap_reg;

endmodule

### sv/rotary_encoder_with_tap.sv
`timescale 1ns / 1ps

// Quadrature encoder decoder with push-switch tap detection.
// The input channel (in_valid/in_ready) carries one pin-edge event per transfer:
// op selects an encoder line edge or a switch edge, with the sampled lines and
// a millisecond tick. The output channel (out_valid/out_ready) returns exactly
// one result per event: the position count after the event, the detent step
// and the tap flag.
// An event is captured in an input register and resolved into the result
// register when that register is empty or its result is being taken, which
// raises out_valid. One event per cycle is sustained while the receiver
// takes results; the single decode and compare pass sets that figure.
// When the receiver stalls, one result waits in the result register and one
// event in the input register, after which in_ready drops.
// Reset clears the decoder, the position count, the time stamps and both
// valid flags; the lockout and holdoff registers return to 10 and 200 ms.
// The configuration port writes register 0 (rotation lockout) or register 1
// (tap holdoff) at any edge with cfg_we high; the user must use it only while idle, as the block does not enforce this.

module rotary_encoder_with_tap #(
    parameter int TICK_WIDTH = rotenc_pkg::TICK_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rotenc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic                                 pin_a,
    input  logic                                 pin_b,
    input  logic                                 pin_sw,
    input  logic [rotenc_pkg::NOW_W-1:0]         now_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rotenc_pkg::POS_W-1:0]  position,
    output logic [1:0]                           step,
    output logic                                 tap
);

    rotenc_pkg::cfg_t  cfg;
    rotenc_pkg::item_t item;
    logic              item_valid;
    logic              item_take;

    rotenc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rotenc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .pin_a      (pin_a),
        .pin_b      (pin_b),
        .pin_sw     (pin_sw),
        .now_ms     (now_ms),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    rotenc_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .step       (step),
        .tap        (tap)
    );

endmodule
